// ----- hdl/assert_macros.svh -----
// Assertion macros for the port checker of the DFS stack block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define MLDS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define MLDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mlds_pkg.sv -----
// Package of the multi-level DFS stack: sizes, field widths, command and status codes.
// Used by mlds_ctrl, the top level multi_level_dfs_stack, mlds_checker and tb_top; no dependencies.
package mlds_pkg;

  localparam int LEVELS      = 8;
  localparam int LEVEL_DEPTH = 256;
  localparam int VERTEX_BITS = 32;
  localparam int PATH_CAP    = 8;

  localparam int LVL_W   = $clog2(LEVELS);
  localparam int PTR_W   = $clog2(LEVEL_DEPTH);
  localparam int CNT_W   = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W  = LVL_W + PTR_W;
  localparam int RAM_DEPTH = 2 ** ADDR_W;
  localparam int USED_W  = $clog2(LEVELS + 1);
  localparam int CMP_W   = LVL_W + 2;

  localparam int CMD_W   = 4;
  localparam int LVLIN_W = 3;
  localparam int LOUT_W  = 4;
  localparam int ST_W    = 2;
  localparam int FILL_W  = 9;
  localparam int TOT_W   = 12;
  localparam int CFG_W   = 4;

  localparam logic [CFG_W-1:0]  CFG_RESET    = 4'd8;
  localparam logic [LOUT_W-1:0] APPEND_LEVEL = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_CUR  = 4'd0,
    CMD_PUSH_NEXT = 4'd1,
    CMD_UPDATE    = 4'd2,
    CMD_DELETE    = 4'd3,
    CMD_READ_TOP  = 4'd4,
    CMD_READ_PATH = 4'd5,
    CMD_DESCEND   = 4'd6,
    CMD_ASCEND    = 4'd7,
    CMD_STATUS    = 4'd8
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Declared from the highest bits down, so the vertex lands in the lowest bits.
  typedef struct packed {
    logic                   is_empty;
    logic [TOT_W-1:0]       states_total;
    logic [FILL_W-1:0]      level_fill;
    logic [LVLIN_W-1:0]     cur_level;
    status_t                status;
    logic [LOUT_W-1:0]      level_out;
    logic [VERTEX_BITS-1:0] vertex_out;
  } result_t;

endpackage

// ----- hdl/mlds_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module mlds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/mlds_ctrl.sv -----
// Command sequencer of the DFS stack: level fill counts, current level, result register.
// Depends on mlds_pkg; drives the vertex store built from mlds_ram.
module mlds_ctrl
  import mlds_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cmd_t                     in_cmd,
  input  logic [VERTEX_BITS-1:0]   in_vertex,
  input  logic [LVLIN_W-1:0]       in_level,
  input  logic [USED_W-1:0]        used_levels,
  output logic                     ram_we,
  output logic [ADDR_W-1:0]        ram_waddr,
  output logic [VERTEX_BITS-1:0]   ram_wdata,
  output logic [ADDR_W-1:0]        ram_raddr,
  input  logic [VERTEX_BITS-1:0]   ram_rdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output result_t                  out_res,
  output logic                     out_last
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_POP, S_RD, S_PATH, S_PRD, S_EMIT
  } state_t;

  state_t                 state;
  cmd_t                   cmd;
  logic [VERTEX_BITS-1:0] vtx;
  logic [LVLIN_W-1:0]     lv;
  logic [CNT_W-1:0]       cnt [LEVELS];
  logic [LVL_W-1:0]       cur;
  logic [LVL_W-1:0]       idx;
  logic [VERTEX_BITS-1:0] vo;
  logic [LOUT_W-1:0]      lo;
  status_t                st;
  logic                   last_r;
  logic                   path_on;

  logic                   can_next;
  logic [LVL_W-1:0]       nxt;
  logic [LVL_W-1:0]       tgt;
  logic                   full;
  logic                   lv_oor;
  logic [LVL_W-1:0]       lv_idx;
  logic [LVL_W-1:0]       rd_lvl;
  logic [PTR_W-1:0]       rd_ptr;
  logic [LVL_W-1:0]       path_end;
  logic [CNT_W-1:0]       pop_cnt;
  logic [TOT_W-1:0]       sum;
  logic [TOT_W-1:0]       total;

  assign nxt      = cur + LVL_W'(1);
  assign can_next = (CMP_W'(cur) + CMP_W'(1)) < CMP_W'(used_levels);
  assign tgt      = (cmd == CMD_PUSH_NEXT) ? nxt : cur;
  assign full     = cnt[tgt] == CNT_W'(LEVEL_DEPTH);
  assign lv_idx   = LVL_W'(lv);
  assign lv_oor   = (CMP_W'(lv) >= CMP_W'(used_levels)) || (int'(lv) >= LEVELS);
  assign rd_lvl   = (state == S_PATH) ? idx : lv_idx;
  assign rd_ptr   = cnt[rd_lvl][PTR_W-1:0] - PTR_W'(1);
  assign path_end = (CMP_W'(cur) < CMP_W'(PATH_CAP - 1)) ? cur : LVL_W'(PATH_CAP - 1);
  assign pop_cnt  = (cnt[cur] == '0) ? '0 : cnt[cur] - CNT_W'(1);

  assign in_ready  = (state == S_IDLE);
  assign ram_we    = (state == S_EXEC) && !full &&
                     ((cmd == CMD_PUSH_CUR) || ((cmd == CMD_PUSH_NEXT) && can_next));
  assign ram_waddr = {tgt, cnt[tgt][PTR_W-1:0]};
  assign ram_wdata = vtx;
  assign ram_raddr = {rd_lvl, rd_ptr};

  always_comb begin
    sum = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (LVL_W'(i) <= cur) begin
        sum = sum + TOT_W'(cnt[i]);
      end
    end
    total = (sum > TOT_W'(cur)) ? sum - TOT_W'(cur) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cur       <= '0;
      idx       <= '0;
      path_on   <= 1'b0;
      last_r    <= 1'b1;
      out_valid <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        cnt[i] <= '0;
      end
    end else begin
      if (out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_cmd;
            vtx   <= in_vertex;
            lv    <= in_level;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          vo     <= '0;
          st     <= ST_OK;
          lo     <= LOUT_W'(cur);
          last_r <= 1'b1;
          state  <= S_EMIT;
          unique case (cmd) inside
            CMD_PUSH_CUR: begin
              if (full) begin
                st <= ST_FULL;
              end else begin
                cnt[cur] <= cnt[cur] + CNT_W'(1);
              end
            end
            CMD_PUSH_NEXT: begin
              if (!can_next) begin
                st <= ST_RANGE;
              end else begin
                lo <= LOUT_W'(nxt);
                if (full) begin
                  st <= ST_FULL;
                end else begin
                  cnt[nxt] <= cnt[nxt] + CNT_W'(1);
                end
              end
            end
            CMD_UPDATE, CMD_DELETE: begin
              if ((cmd == CMD_UPDATE) && can_next && (cnt[nxt] != '0)) begin
                cur <= nxt;
                lo  <= LOUT_W'(nxt);
              end else begin
                st    <= (cnt[cur] == '0) ? ST_EMPTY : ST_OK;
                state <= S_POP;
              end
            end
            CMD_READ_TOP: begin
              lo <= LOUT_W'(lv);
              if (lv_oor) begin
                st <= ST_RANGE;
              end else if (cnt[lv_idx] == '0) begin
                st <= ST_EMPTY;
              end else begin
                state <= S_RD;
              end
            end
            CMD_READ_PATH: begin
              idx     <= '0;
              path_on <= 1'b1;
              state   <= S_PATH;
            end
            CMD_DESCEND: begin
              if (!can_next) begin
                st <= ST_RANGE;
              end else begin
                cur <= nxt;
                lo  <= LOUT_W'(nxt);
              end
            end
            CMD_ASCEND: begin
              if (cur == '0) begin
                st <= ST_RANGE;
              end else begin
                cur <= cur - LVL_W'(1);
                lo  <= LOUT_W'(cur - LVL_W'(1));
              end
            end
            default: begin
            end
          endcase
        end
        S_POP: begin
          cnt[cur] <= pop_cnt;
          if ((pop_cnt != '0) || (cur == '0)) begin
            lo    <= LOUT_W'(cur);
            state <= S_EMIT;
          end else begin
            cur <= cur - LVL_W'(1);
          end
        end
        S_RD: begin
          vo    <= ram_rdata;
          state <= S_EMIT;
        end
        S_PATH: begin
          state <= S_PRD;
        end
        S_PRD: begin
          lo     <= LOUT_W'(idx);
          last_r <= 1'b0;
          if (cnt[idx] != '0) begin
            vo <= ram_rdata;
            st <= ST_OK;
          end else begin
            vo <= '0;
            st <= ST_EMPTY;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_last                 <= last_r;
            out_res.vertex_out       <= vo;
            out_res.level_out        <= lo;
            out_res.status           <= st;
            out_res.cur_level        <= LVLIN_W'(cur);
            out_res.level_fill       <= FILL_W'(cnt[cur]);
            out_res.states_total     <= total;
            out_res.is_empty         <= (cur == '0) && (cnt[0] == '0);
            if (path_on) begin
              if (idx == path_end) begin
                vo      <= vtx;
                lo      <= APPEND_LEVEL;
                st      <= ST_OK;
                last_r  <= 1'b1;
                path_on <= 1'b0;
              end else begin
                idx   <= idx + LVL_W'(1);
                state <= S_PATH;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/multi_level_dfs_stack.sv -----
// A result beat passes through the execute state and then the result register; read top adds
// the store read state before the result register, and backtracking adds a pop state per level.
// Read path gives one beat per level, each through the path, store read and result register
// states in turn, and then the appended vertex beat from the result register.
// One command is in flight at a time, so a new one is taken only after the last result beat is
// registered; a result waits while the output register holds an untaken beat. Synchronous
// active-high reset empties all levels, sets level 0 and 8 levels in use; the vertex store itself is not cleared.
module multi_level_dfs_stack
  import mlds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // vertex[31:0], level[34:32], zero fill
  input  logic [3:0]  s_tuser,   // command[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // vertex_out, level_out, status, current_level_out,
                                 // level_fill, states_total, is_empty, zero fill
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data   // levels_in_use
);

  logic [CFG_W-1:0]       cfg_r;
  logic [USED_W-1:0]      used_levels;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [VERTEX_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [VERTEX_BITS-1:0] ram_rdata;
  result_t                res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      cfg_r <= cfg_data;
    end
  end

  always_comb begin
    if (cfg_r == '0) begin
      used_levels = USED_W'(1);
    end else if (int'(cfg_r) > LEVELS) begin
      used_levels = USED_W'(LEVELS);
    end else begin
      used_levels = USED_W'(cfg_r);
    end
  end

  mlds_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_cmd      (cmd_t'(s_tuser)),
    .in_vertex   (s_tdata[31:0]),
    .in_level    (s_tdata[34:32]),
    .used_levels (used_levels),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res),
    .out_last    (m_tlast)
  );

  mlds_ram #(
    .WIDTH (VERTEX_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign m_tdata = {1'b0, res};

endmodule

// ----- hdl/mlds_checker.sv -----
// Port-level checker for multi_level_dfs_stack, attached by the bind at the end of this file.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mlds_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  logic       stalled;
  logic       taken;
  logic       empty_flag;
  logic [2:0] level_now;
  logic [8:0] fill_now;

  assign stalled    = m_tvalid && !m_tready;
  assign taken      = s_tvalid && s_tready;
  assign empty_flag = m_tdata[62];
  assign level_now  = m_tdata[40:38];
  assign fill_now   = m_tdata[49:41];

  `MLDS_ASSERT(a_out_hold, clk, rst, stalled |=> m_tvalid && $stable(m_tdata), "beat moved")
  `MLDS_ASSERT(a_one_cmd, clk, rst, taken |=> !s_tready, "second command while busy")
  `MLDS_ASSERT(a_empty_flag, clk, rst, m_tvalid && empty_flag |-> !(|{level_now, fill_now}), "bad empty")
  `MLDS_ASSERT(a_fill_range, clk, rst, m_tvalid |-> fill_now <= 9'd256, "fill above depth")
  `MLDS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid, "beat valid after reset")

endmodule

bind multi_level_dfs_stack mlds_port_checker u_checker (.*);

// ----- sim/mlds_checker.sv -----
// Checker of the multi-level DFS stack: watches the command, result and register channels,
// keeps its own copy of the levels and compares every result beat. Depends on mlds_pkg.
module mlds_checker
  import mlds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // vertex[31:0], level[34:32], zero fill
  input  logic [3:0]  s_tuser,   // command[3:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // vertex_out, level_out, status, current_level_out,
                                 // level_fill, states_total, is_empty, zero fill
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,  // levels_in_use
  output int          fail_count,
  output int          results_due
);

  typedef struct packed {
    logic    last;
    result_t beat;
  } stack_reply_t;

  logic [VERTEX_BITS-1:0] vertex_mem [LEVELS][LEVEL_DEPTH];
  int unsigned            fill [LEVELS];
  int unsigned            depth;
  logic [CFG_W-1:0]       levels_cfg;
  stack_reply_t           replies_due [$];
  int                     errs = 0;

  function automatic result_t make_reply(logic [VERTEX_BITS-1:0] v, logic [LOUT_W-1:0] lo,
                                         status_t st);
    result_t     r;
    int unsigned sum;
    int unsigned i;
    sum = 0;
    for (i = 0; i <= depth; i++) sum += fill[i];
    sum = (sum > depth) ? sum - depth : 0;
    r.vertex_out    = v;
    r.level_out     = lo;
    r.status        = st;
    r.cur_level     = LVLIN_W'(depth);
    r.level_fill    = FILL_W'(fill[depth]);
    r.states_total  = TOT_W'(sum);
    r.is_empty      = (depth == 0 && fill[0] == 0);
    return r;
  endfunction

  function automatic status_t push_vertex(int unsigned lv, logic [VERTEX_BITS-1:0] v);
    if (fill[lv] >= LEVEL_DEPTH) return ST_FULL;
    vertex_mem[lv][fill[lv]] = v;
    fill[lv] = fill[lv] + 1;
    return ST_OK;
  endfunction

  // Pops the current top, then keeps ascending and popping while a level runs dry.
  function automatic status_t backtrack_path();
    status_t st;
    bit      stop;
    st = (fill[depth] == 0) ? ST_EMPTY : ST_OK;
    do begin
      if (fill[depth] > 0) fill[depth] = fill[depth] - 1;
      stop = (fill[depth] != 0) || (depth == 0);
      if (!stop) depth = depth - 1;
    end while (!stop);
    return st;
  endfunction

  function automatic void run_command(logic [CMD_W-1:0] code, logic [VERTEX_BITS-1:0] v,
                                      logic [LVLIN_W-1:0] lv);
    int unsigned            used;
    int unsigned            i;
    status_t                st;
    logic [VERTEX_BITS-1:0] vo;
    logic [LOUT_W-1:0]      lo;
    stack_reply_t           rep;
    used = (levels_cfg < 1) ? 1 : (levels_cfg > LEVELS) ? LEVELS : levels_cfg;
    st = ST_OK;
    vo = '0;
    lo = LOUT_W'(depth);
    case (code)
      CMD_PUSH_CUR: st = push_vertex(depth, v);
      CMD_PUSH_NEXT: begin
        if (depth + 1 >= used) begin
          st = ST_RANGE;
        end else begin
          lo = LOUT_W'(depth + 1);
          st = push_vertex(depth + 1, v);
        end
      end
      CMD_UPDATE: begin
        if (depth + 1 < used && fill[depth + 1] > 0) depth = depth + 1;
        else st = backtrack_path();
        lo = LOUT_W'(depth);
      end
      CMD_DELETE: begin
        st = backtrack_path();
        lo = LOUT_W'(depth);
      end
      CMD_READ_TOP: begin
        lo = {1'b0, lv};
        if (lv >= used) st = ST_RANGE;
        else if (fill[lv] == 0) st = ST_EMPTY;
        else vo = vertex_mem[lv][fill[lv] - 1];
      end
      CMD_READ_PATH: begin
        for (i = 0; i <= depth && i < PATH_CAP; i++) begin
          rep.last = 1'b0;
          if (fill[i] > 0) rep.beat = make_reply(vertex_mem[i][fill[i] - 1], LOUT_W'(i), ST_OK);
          else rep.beat = make_reply('0, LOUT_W'(i), ST_EMPTY);
          replies_due.push_back(rep);
        end
        rep.last = 1'b1;
        rep.beat = make_reply(v, APPEND_LEVEL, ST_OK);
        replies_due.push_back(rep);
        return;
      end
      CMD_DESCEND: begin
        if (depth + 1 >= used) st = ST_RANGE;
        else depth = depth + 1;
        lo = LOUT_W'(depth);
      end
      CMD_ASCEND: begin
        if (depth == 0) st = ST_RANGE;
        else depth = depth - 1;
        lo = LOUT_W'(depth);
      end
      default: ;
    endcase
    rep.last = 1'b1;
    rep.beat = make_reply(vo, lo, st);
    replies_due.push_back(rep);
  endfunction

  function automatic bit field_ok(string name, logic [VERTEX_BITS-1:0] want,
                                  logic [VERTEX_BITS-1:0] got);
    if (want === got) return 1'b1;
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    stack_reply_t want;
    result_t      got;
    bit           ok;
    if (rst) begin
      foreach (fill[i]) fill[i] = 0;
      depth = 0;
      levels_cfg = CFG_RESET;
      replies_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (replies_due.size() == 0) begin
          $display("%0t: result beat %h arrived with none expected", $time, m_tdata);
          errs++;
        end else begin
          want = replies_due.pop_front();
          ok = field_ok("vertex_out", want.beat.vertex_out, got.vertex_out);
          ok = field_ok("level_out", want.beat.level_out, got.level_out) & ok;
          ok = field_ok("status", want.beat.status, got.status) & ok;
          ok = field_ok("current_level_out", want.beat.cur_level, got.cur_level) & ok;
          ok = field_ok("level_fill", want.beat.level_fill, got.level_fill) & ok;
          ok = field_ok("states_total", want.beat.states_total, got.states_total) & ok;
          ok = field_ok("is_empty", want.beat.is_empty, got.is_empty) & ok;
          ok = field_ok("last", want.last, m_tlast) & ok;
          if (!ok) errs++;
        end
      end
      if (cfg_valid && cfg_ready) levels_cfg = cfg_data;
      if (s_tvalid && s_tready) run_command(s_tuser, s_tdata[31:0], s_tdata[34:32]);
    end
    fail_count  <= errs;
    results_due <= replies_due.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Top of the DFS stack testbench: clock, reset, commands, register writes and result back-pressure.
// Instantiates multi_level_dfs_stack and mlds_checker; depends on mlds_pkg.
module tb_top
  import mlds_pkg::*;
();

  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_PUSHES = 30;
  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_data = '0;

  int   fail_count;
  int   results_due;
  int   src_idle = 0;
  int   sink_idle = 0;
  logic hold_tog = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  multi_level_dfs_stack DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  mlds_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A toggle of hold_tog starts a long stretch in which no result beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_tog;
    end else if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("FAIL multi_level_dfs_stack");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic [CMD_W-1:0] code, input logic [VERTEX_BITS-1:0] vtx,
                      input logic [LVLIN_W-1:0] lvl);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, lvl, vtx};
    s_tuser  <= code;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_levels(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int                     k;
    int                     pick;
    logic [CMD_W-1:0]       code;
    logic [VERTEX_BITS-1:0] vtx;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 22) code = CMD_PUSH_CUR;
      else if (pick < 42) code = CMD_PUSH_NEXT;
      else if (pick < 62) code = CMD_UPDATE;
      else if (pick < 69) code = CMD_DELETE;
      else if (pick < 77) code = CMD_READ_TOP;
      else if (pick < 85) code = CMD_READ_PATH;
      else if (pick < 90) code = CMD_DESCEND;
      else if (pick < 95) code = CMD_ASCEND;
      else if (pick < 97) code = CMD_STATUS;
      else code = CMD_W'($urandom_range({CMD_W{1'b1}}, CMD_STATUS + 1));
      case ($urandom_range(7))
        0: vtx = '0;
        1: vtx = '1;
        default: vtx = $urandom;
      endcase
      send(code, vtx, LVLIN_W'($urandom_range(LEVELS - 1)));
    end
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    src_idle = 24;
    sink_idle <= 73;
    write_levels(4'd8);

    send(CMD_STATUS, '0, 3'd0);
    send(CMD_READ_TOP, '0, 3'd0);
    send(CMD_READ_PATH, '1, 3'd0);
    send(CMD_ASCEND, '0, 3'd0);
    send(CMD_UPDATE, '0, 3'd0);
    send(CMD_DELETE, '0, 3'd0);
    send(CMD_PUSH_CUR, '0, 3'd0);
    send(CMD_PUSH_CUR, '1, 3'd7);
    send(CMD_PUSH_NEXT, 32'hA5A5_A5A5, 3'd0);
    send(CMD_PUSH_NEXT, 32'h5A5A_5A5A, 3'd0);
    send(CMD_READ_TOP, '0, 3'd1);
    send(CMD_UPDATE, '0, 3'd0);
    send(CMD_PUSH_NEXT, 32'h1234_5678, 3'd0);
    send(CMD_DESCEND, '0, 3'd0);
    send(CMD_READ_PATH, 32'h8000_0001, 3'd0);
    send(CMD_ASCEND, '0, 3'd0);
    send(CMD_UPDATE, '0, 3'd0);
    send(CMD_UPDATE, '0, 3'd0);
    send(CMD_READ_TOP, '0, 3'd7);
    send(CMD_W'(CMD_STATUS + 1), '0, 3'd0);
    send({CMD_W{1'b1}}, '1, 3'd7);
    drain();
    // With two levels in use the current level 1 is the last one.
    write_levels(4'd2);
    send(CMD_DESCEND, '0, 3'd0);
    send(CMD_PUSH_NEXT, 32'hDEAD_BEEF, 3'd0);
    send(CMD_READ_TOP, '0, 3'd2);
    drain();
    write_levels(4'd1);
    send(CMD_UPDATE, '0, 3'd0);
    drain();

    write_levels(4'd15);
    run_random(34);
    drain();
    write_levels(4'd5);
    run_random(34);
    drain();

    src_idle = 73;
    sink_idle <= 24;
    write_levels(4'd3);
    run_random(34);
    drain();
    write_levels(4'd0);
    run_random(33);
    drain();

    src_idle = 0;
    sink_idle <= 0;
    write_levels(4'd8);
    run_random(33);
    drain();
    write_levels(4'd7);
    run_random(32);
    drain();

    // Results are held back for a long stretch while commands keep coming.
    hold_tog <= ~hold_tog;
    for (k = 0; k < HOLD_PUSHES; k++) send(CMD_PUSH_CUR, $urandom, 3'd0);
    send(CMD_READ_PATH, $urandom, 3'd0);
    send(CMD_STATUS, '0, 3'd0);
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS multi_level_dfs_stack");
    end else begin
      $display("FAIL multi_level_dfs_stack");
    end
    $finish;
  end

endmodule
